[hw/rtl/array_linked_list_engine_assert.svh]
// Assertion macros for the array linked list engine.
`ifndef ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define ALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ale_pkg.sv]
// Types, codes and operations shared by the array linked list engine.
`timescale 1ns / 1ps

package ale_pkg;

  localparam logic [2:0] CMD_ADD_FRONT = 3'd0;
  localparam logic [2:0] CMD_ADD_AFTER = 3'd1;
  localparam logic [2:0] CMD_ADD_END   = 3'd2;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [2:0] CMD_DEL_AFTER = 3'd4;
  localparam logic [2:0] CMD_DEL_END   = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BADPREV = 2'd3;

  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_CLEAR      = 4'd1;
  localparam logic [3:0] OP_LOAD       = 4'd2;
  localparam logic [3:0] OP_CHECK      = 4'd3;
  localparam logic [3:0] OP_WALK       = 4'd4;
  localparam logic [3:0] OP_FREE       = 4'd5;
  localparam logic [3:0] OP_ADD_LINK   = 4'd6;
  localparam logic [3:0] OP_DEL_HEAD   = 4'd7;
  localparam logic [3:0] OP_DEL_TAIL   = 4'd8;
  localparam logic [3:0] OP_DEL_AFTER  = 4'd9;
  localparam logic [3:0] OP_RESULT     = 4'd10;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] payload;
    logic [3:0]  prev_slot;
  } ale_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic [4:0] node_count;
    logic [4:0] head_slot;
  } ale_rsp_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] code;
  } ale_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       clr_last;
    logic       full;
    logic       empty;
    logic       zero;
    logic       prev_ok;
    logic       prev_succ;
    logic       one_left;
    logic       walk_end;
    logic       free_found;
    logic       front;
  } ale_sts_t;

endpackage

[hw/rtl/ale_ctrl.sv]
// Controller state machine of the array linked list engine.
`timescale 1ns / 1ps

module ale_ctrl import ale_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output ale_ctl_t ctl,
  input  ale_sts_t sts
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_DELT   = 4'd4;
  localparam logic [3:0] S_FREE   = 4'd5;
  localparam logic [3:0] S_LINK   = 4'd6;
  localparam logic [3:0] S_DELH   = 4'd7;
  localparam logic [3:0] S_DELA   = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] code;
  logic [1:0] code_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    code_next      = code;
    rsp_valid_next = rsp_valid && !rsp_ready;
    ctl.op         = OP_NONE;
    ctl.code       = code;
    case (state)
      S_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.op     = OP_CHECK;
        code_next  = ST_DONE;
        state_next = S_RESULT;
        case (sts.cmd)
          CMD_ADD_FRONT, CMD_ADD_AFTER, CMD_ADD_END: begin
            if (sts.full) begin
              code_next = ST_FULL;
            end else if (sts.cmd == CMD_ADD_AFTER && !sts.prev_ok) begin
              code_next = ST_BADPREV;
            end else if (sts.cmd == CMD_ADD_END && !sts.empty) begin
              state_next = S_WALK;
            end else begin
              state_next = S_FREE;
            end
          end
          CMD_DEL_FRONT: begin
            if (sts.empty) begin
              code_next = ST_EMPTY;
            end else begin
              state_next = S_DELH;
            end
          end
          CMD_DEL_END: begin
            if (sts.empty) begin
              code_next = ST_EMPTY;
            end else if (sts.one_left) begin
              state_next = S_DELH;
            end else begin
              state_next = S_WALK;
            end
          end
          CMD_DEL_AFTER: begin
            if (sts.empty) begin
              code_next = ST_EMPTY;
            end else if (!sts.prev_ok || !sts.prev_succ) begin
              code_next = ST_BADPREV;
            end else begin
              state_next = S_DELA;
            end
          end
          default: begin
            code_next = ST_DONE;
          end
        endcase
      end
      S_WALK: begin
        ctl.op = OP_WALK;
        if (sts.walk_end) begin
          state_next = (sts.cmd == CMD_DEL_END) ? S_DELT : S_FREE;
        end
      end
      S_DELT: begin
        ctl.op     = OP_DEL_TAIL;
        state_next = S_RESULT;
      end
      S_FREE: begin
        ctl.op = OP_FREE;
        if (sts.free_found) begin
          state_next = sts.front ? S_RESULT : S_LINK;
        end
      end
      S_LINK: begin
        ctl.op     = OP_ADD_LINK;
        state_next = S_RESULT;
      end
      S_DELH: begin
        ctl.op     = OP_DEL_HEAD;
        state_next = S_RESULT;
      end
      S_DELA: begin
        ctl.op     = OP_DEL_AFTER;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          ctl.op         = OP_RESULT;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      code      <= ST_DONE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      code      <= code_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

[hw/rtl/ale_dpath.sv]
// Datapath of the array linked list engine: slot memories, list registers, result.
`timescale 1ns / 1ps

module ale_dpath import ale_pkg::*; #(
  parameter int SLOTS        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  ale_req_t req_data,
  input  ale_ctl_t ctl,
  output ale_sts_t sts,
  output ale_rsp_t rsp_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  logic [PW-1:0]           link_mem [SLOTS];
  logic                    use_mem  [SLOTS];
  logic [PAYLOAD_BITS-1:0] pay_mem  [SLOTS];

  logic [PW-1:0] link_q;
  logic          use_q;

  logic          link_we;
  logic [IW-1:0] link_wa;
  logic [PW-1:0] link_wd;
  logic [IW-1:0] link_ra;
  logic          use_we;
  logic [IW-1:0] use_wa;
  logic          use_wd;
  logic [IW-1:0] use_ra;
  logic          pay_we;

  logic [2:0]    cmd_q;
  logic [31:0]   payload_q;
  logic [3:0]    prev_q;
  logic          prev_rng_q;
  logic [IW-1:0] prev_idx;
  logic [IW-1:0] clr;
  logic [PW-1:0] head;
  logic [PW-1:0] count;
  logic [PW-1:0] cur;
  logic [PW-1:0] prv;
  logic [PW-1:0] nsucc;
  logic [PW-1:0] fidx;
  logic [IW-1:0] fchk;
  logic [IW-1:0] res_slot;
  logic [PW-1:0] n_link;

  function automatic logic [PW-1:0] succ(input logic [PW-1:0] v);
    succ = (v < NIL) ? v : NIL;
  endfunction

  assign prev_idx = IW'(prev_q);
  assign n_link   = succ(link_q);

  always_comb begin
    sts.cmd        = cmd_q;
    sts.clr_last   = (clr == IW'(SLOTS - 1));
    sts.full       = (count == NIL);
    sts.empty      = (head == NIL);
    sts.zero       = (count == '0);
    sts.prev_ok    = prev_rng_q && use_q;
    sts.prev_succ  = (n_link != NIL);
    sts.one_left   = (count <= PW'(1));
    sts.walk_end   = (n_link == NIL);
    sts.free_found = !use_q;
    sts.front      = (cmd_q == CMD_ADD_FRONT) || (head == NIL);
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = cur[IW-1:0];
    link_wd = NIL;
    link_ra = cur[IW-1:0];
    use_we  = 1'b0;
    use_wa  = fchk;
    use_wd  = 1'b0;
    use_ra  = fidx[IW-1:0];
    pay_we  = 1'b0;
    case (ctl.op)
      OP_CLEAR: begin
        use_we = 1'b1;
        use_wa = clr;
      end
      OP_LOAD: begin
        link_ra = IW'(req_data.prev_slot);
        use_ra  = IW'(req_data.prev_slot);
      end
      OP_CHECK: begin
        link_ra = (cmd_q == CMD_DEL_AFTER) ? link_q[IW-1:0] : head[IW-1:0];
        use_ra  = '0;
      end
      OP_WALK: begin
        link_ra = n_link[IW-1:0];
        use_ra  = '0;
      end
      OP_FREE: begin
        if (sts.free_found) begin
          use_we  = 1'b1;
          use_wa  = fchk;
          use_wd  = 1'b1;
          pay_we  = 1'b1;
          link_we = 1'b1;
          link_wa = fchk;
          if (sts.front) begin
            link_wd = head;
          end else if (cmd_q == CMD_ADD_AFTER) begin
            link_wd = nsucc;
          end else begin
            link_wd = NIL;
          end
        end
      end
      OP_ADD_LINK: begin
        link_we = 1'b1;
        link_wa = (cmd_q == CMD_ADD_AFTER) ? prev_idx : cur[IW-1:0];
        link_wd = PW'(res_slot);
      end
      OP_DEL_HEAD: begin
        use_we = 1'b1;
        use_wa = head[IW-1:0];
      end
      OP_DEL_TAIL: begin
        use_we = 1'b1;
        use_wa = cur[IW-1:0];
        if (prv != NIL) begin
          link_we = 1'b1;
          link_wa = prv[IW-1:0];
          link_wd = NIL;
        end
      end
      OP_DEL_AFTER: begin
        link_we = 1'b1;
        link_wa = prev_idx;
        link_wd = n_link;
        use_we  = 1'b1;
        use_wa  = nsucc[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    use_q <= use_mem[use_ra];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[fchk] <= PAYLOAD_BITS'(payload_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr   <= '0;
      head  <= NIL;
      count <= '0;
    end else begin
      case (ctl.op)
        OP_CLEAR: begin
          clr <= clr + 1'b1;
        end
        OP_FREE: begin
          if (sts.free_found) begin
            count <= count + 1'b1;
            if (sts.front) begin
              head <= PW'(fchk);
            end
          end
        end
        OP_DEL_HEAD: begin
          head  <= n_link;
          count <= count - 1'b1;
        end
        OP_DEL_TAIL: begin
          if (prv == NIL) begin
            head <= NIL;
          end
          count <= count - 1'b1;
        end
        OP_DEL_AFTER: begin
          count <= count - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd_q      <= req_data.command;
        payload_q  <= req_data.payload;
        prev_q     <= req_data.prev_slot;
        prev_rng_q <= (32'(req_data.prev_slot) < SLOTS);
      end
      OP_CHECK: begin
        nsucc    <= n_link;
        cur      <= head;
        prv      <= NIL;
        fidx     <= PW'(1);
        fchk     <= '0;
        res_slot <= '0;
      end
      OP_WALK: begin
        if (!sts.walk_end) begin
          prv <= cur;
          cur <= n_link;
        end
        fidx <= PW'(1);
        fchk <= '0;
      end
      OP_FREE: begin
        if (sts.free_found) begin
          res_slot <= fchk;
        end else begin
          fchk <= fidx[IW-1:0];
          fidx <= fidx + 1'b1;
        end
      end
      OP_DEL_HEAD: begin
        res_slot <= head[IW-1:0];
      end
      OP_DEL_TAIL: begin
        res_slot <= cur[IW-1:0];
      end
      OP_DEL_AFTER: begin
        res_slot <= nsucc[IW-1:0];
      end
      OP_RESULT: begin
        rsp_data.status     <= ctl.code;
        rsp_data.slot       <= 4'(res_slot);
        rsp_data.node_count <= 5'(count);
        rsp_data.head_slot  <= 5'(head);
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/array_linked_list_engine.sv]
// Top level of the array linked list engine: controller plus datapath.
//
//   channel  handshake                 payload
//   request  req_valid / req_ready     req_data (ale_req_t)
//   response rsp_valid / rsp_ready     rsp_data (ale_rsp_t)
//
// One request at a time. A rejected or ignored request goes from the check straight to the
// result; delete front and delete after take one update step; delete end first walks to
// the tail unless one node is left. An add probes for a free slot from slot 0, links the new
// node behind another unless it goes in front; a non-empty add end first walks to the tail.
// After reset every slot of the slot-use memory is swept clear; req_ready stays low until then.
// The next request is taken while a response waits; its result holds until that one goes.
`timescale 1ns / 1ps

module array_linked_list_engine import ale_pkg::*; #(
  parameter int SLOTS        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ale_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output ale_rsp_t rsp_data
);

  `include "array_linked_list_engine_assert.svh"

  ale_ctl_t ctl;
  ale_sts_t sts;

  ale_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  ale_dpath #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .ctl      (ctl),
    .sts      (sts),
    .rsp_data (rsp_data)
  );

  `ALE_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready after accept")
  `ALE_ASSERT_NOW(a_free_not_full, ctl.op == OP_FREE, !sts.full, "free search on full list")
  `ALE_ASSERT_NOW(a_head_count, 1'b1, sts.empty == sts.zero, "head and count disagree")
  `ALE_ASSERT_NEXT(a_result_out, ctl.op == OP_RESULT, rsp_valid && req_ready, "result lost")

endmodule

[verif/tb.sv]
// Self-checking bench for the array linked list engine: slot-list predictor and stalling drivers.
`timescale 1ns / 1ps

module tb;
  import ale_pkg::*;

  localparam int LIST_SLOTS   = 16;
  localparam int RUN_LIMIT    = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 60;
  localparam int PHASE_ITEMS  = 300;
  localparam int FLOOD_ITEMS  = 40;
  localparam int SHOWN_ERRORS = 40;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef enum int {FILL_UP, DRAIN_DOWN, CHURN} burst_mode_t;

  class list_board;
    logic [4:0] next_of [LIST_SLOTS];
    bit         in_use [LIST_SLOTS];
    logic [4:0] head;
    logic [4:0] length;
    ale_rsp_t   awaited_rsp [$];
    int         mismatches;
    int         requests;
    int         responses;
    int         outcome_tally [4];

    function new();
      for (int i = 0; i < LIST_SLOTS; i++) begin
        next_of[i] = 5'(LIST_SLOTS);
        in_use[i] = 1'b0;
      end
      head = 5'(LIST_SLOTS);
      length = '0;
      mismatches = 0;
      requests = 0;
      responses = 0;
      for (int i = 0; i < 4; i++) outcome_tally[i] = 0;
    endfunction

    function logic [4:0] succ_of(logic [4:0] s);
      logic [4:0] n;
      n = next_of[s[3:0]];
      return (n < LIST_SLOTS) ? n : 5'(LIST_SLOTS);
    endfunction

    function logic [4:0] tail_of(output logic [4:0] prior);
      logic [4:0] cur;
      logic [4:0] nx;
      cur = head;
      prior = 5'(LIST_SLOTS);
      for (int steps = 0; steps < LIST_SLOTS; steps++) begin
        nx = succ_of(cur);
        if (nx == LIST_SLOTS) break;
        prior = cur;
        cur = nx;
      end
      return cur;
    endfunction

    function logic [4:0] take_slot();
      logic [4:0] s;
      s = 5'(LIST_SLOTS);
      for (int i = LIST_SLOTS - 1; i >= 0; i--) if (!in_use[i]) s = 5'(i);
      in_use[s[3:0]] = 1'b1;
      length++;
      return s;
    endfunction

    function void free_node(logic [4:0] s);
      in_use[s[3:0]] = 1'b0;
      next_of[s[3:0]] = 5'(LIST_SLOTS);
      length--;
    endfunction

    function ale_rsp_t apply_command(ale_req_t r);
      ale_rsp_t o;
      logic [4:0] s;
      logic [4:0] t;
      logic [4:0] prior;
      bit prev_ok;
      o = '0;
      o.status = ST_DONE;
      prev_ok = in_use[r.prev_slot];
      case (r.command)
        CMD_ADD_FRONT, CMD_ADD_AFTER, CMD_ADD_END: begin
          if (length >= LIST_SLOTS) begin
            o.status = ST_FULL;
          end else if (r.command == CMD_ADD_AFTER && !prev_ok) begin
            o.status = ST_BADPREV;
          end else if (r.command == CMD_ADD_FRONT || head == LIST_SLOTS) begin
            s = take_slot();
            next_of[s[3:0]] = head;
            head = s;
            o.slot = s[3:0];
          end else begin
            t = (r.command == CMD_ADD_AFTER) ? {1'b0, r.prev_slot} : tail_of(prior);
            s = take_slot();
            next_of[s[3:0]] = succ_of(t);
            next_of[t[3:0]] = s;
            o.slot = s[3:0];
          end
        end
        CMD_DEL_FRONT, CMD_DEL_END: begin
          if (head == LIST_SLOTS) begin
            o.status = ST_EMPTY;
          end else begin
            if (r.command == CMD_DEL_FRONT || length <= 1) begin
              s = head;
              head = succ_of(s);
            end else begin
              s = tail_of(prior);
              if (prior == LIST_SLOTS) head = 5'(LIST_SLOTS);
              else next_of[prior[3:0]] = 5'(LIST_SLOTS);
            end
            free_node(s);
            o.slot = s[3:0];
          end
        end
        CMD_DEL_AFTER: begin
          if (head == LIST_SLOTS) begin
            o.status = ST_EMPTY;
          end else if (!prev_ok || succ_of({1'b0, r.prev_slot}) == LIST_SLOTS) begin
            o.status = ST_BADPREV;
          end else begin
            s = succ_of({1'b0, r.prev_slot});
            next_of[r.prev_slot] = succ_of(s);
            free_node(s);
            o.slot = s[3:0];
          end
        end
        default: ;
      endcase
      o.node_count = length;
      o.head_slot = head;
      return o;
    endfunction

    task report_mismatch(string what);
      if (mismatches < SHOWN_ERRORS) $display("mismatch: %s", what);
      mismatches++;
    endtask

    function void note_request(ale_req_t r);
      awaited_rsp.push_back(apply_command(r));
      requests++;
    endfunction

    task check_response(ale_rsp_t got);
      ale_rsp_t want;
      responses++;
      if (awaited_rsp.size() == 0) begin
        report_mismatch($sformatf("response %0d arrived with none pending", responses));
      end else begin
        want = awaited_rsp.pop_front();
        outcome_tally[want.status]++;
        if (got.status !== want.status)
          report_mismatch($sformatf("response %0d status %0d, want %0d",
                                    responses, got.status, want.status));
        if (got.slot !== want.slot)
          report_mismatch($sformatf("response %0d slot %0d, want %0d",
                                    responses, got.slot, want.slot));
        if (got.node_count !== want.node_count)
          report_mismatch($sformatf("response %0d node_count %0d, want %0d",
                                    responses, got.node_count, want.node_count));
        if (got.head_slot !== want.head_slot)
          report_mismatch($sformatf("response %0d head_slot %0d, want %0d",
                                    responses, got.head_slot, want.head_slot));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  ale_req_t req_data = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  ale_rsp_t rsp_data;

  list_board sb = new();
  int        gap_pct = 0;
  int        stall_pct = 0;
  bit        hold_go = 1'b0;
  int        hold_count = 0;
  int        cycle_count = 0;

  array_linked_list_engine uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles, %0d responses pending", cycle_count,
             sb.awaited_rsp.size());
    $display("CHECK FAILED");
    $finish;
  end

  // hold off for a long stretch when asked, otherwise stall at random
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp_data);
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_go) begin
      rsp_ready <= 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) begin
        hold_go = 1'b0;
        hold_count = 0;
      end
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [3:0] pick_node(bit with_succ);
    int cand [$];
    for (int i = 0; i < LIST_SLOTS; i++)
      if (sb.in_use[i] && (!with_succ || sb.succ_of(5'(i)) != LIST_SLOTS)) cand.push_back(i);
    if (cand.size() == 0) return 4'($urandom_range(LIST_SLOTS - 1));
    return 4'(cand[$urandom_range(cand.size() - 1)]);
  endfunction

  function automatic ale_req_t make_request(burst_mode_t mode);
    ale_req_t r;
    int roll;
    roll = $urandom_range(99);
    r.payload = $urandom;
    if ($urandom_range(15) == 0) r.payload = $urandom_range(1) ? '1 : '0;
    if (roll < 3) r.command = 3'($urandom_range(CMD_SPARE_B));
    else if (mode == FILL_UP) r.command = 3'($urandom_range(CMD_ADD_END, CMD_ADD_FRONT));
    else if (mode == DRAIN_DOWN) r.command = 3'($urandom_range(CMD_DEL_END, CMD_DEL_FRONT));
    else r.command = 3'($urandom_range(CMD_DEL_END, CMD_ADD_FRONT));
    r.prev_slot = 4'($urandom_range(LIST_SLOTS - 1));
    if ($urandom_range(9) != 0) begin
      if (r.command == CMD_ADD_AFTER) r.prev_slot = pick_node(1'b0);
      else if (r.command == CMD_DEL_AFTER) r.prev_slot = pick_node(1'b1);
    end
    return r;
  endfunction

  task automatic send_req(ale_req_t r);
    while ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  task automatic run_random(int n);
    burst_mode_t mode;
    int left;
    mode = CHURN;
    left = 0;
    repeat (n) begin
      if (left == 0) begin
        mode = burst_mode_t'($urandom_range(CHURN));
        left = $urandom_range(40, 8);
      end
      send_req(make_request(mode));
      left--;
    end
  endtask

  task automatic park_and_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited_rsp.size() != 0);
  endtask

  initial begin
    int gap_plan [4];
    int stall_plan [4];
    gap_plan = '{0, 78, 0, 24};
    stall_plan = '{0, 0, 78, 24};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_req('{CMD_DEL_FRONT, 32'h0, 4'd0});
    send_req('{CMD_DEL_AFTER, 32'h0, 4'd0});
    send_req('{CMD_DEL_END, 32'h0, 4'd0});
    send_req('{CMD_ADD_AFTER, 32'h1234_5678, 4'd15});
    send_req('{CMD_SPARE_A, 32'h0, 4'd0});
    send_req('{CMD_SPARE_B, 32'hFFFF_FFFF, 4'd15});
    send_req('{CMD_ADD_FRONT, 32'h0, 4'd0});
    send_req('{CMD_ADD_END, 32'hFFFF_FFFF, 4'd15});
    send_req('{CMD_ADD_AFTER, 32'hA5A5_5A5A, 4'd0});
    send_req('{CMD_DEL_AFTER, 32'h0, 4'd1});
    send_req('{CMD_DEL_AFTER, 32'h0, 4'd15});
    send_req('{CMD_DEL_AFTER, 32'h0, 4'd0});
    send_req('{CMD_DEL_END, 32'h0, 4'd0});
    send_req('{CMD_DEL_END, 32'h0, 4'd0});
    park_and_drain();

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gap_plan[ph];
      stall_pct = stall_plan[ph];
      run_random(PHASE_ITEMS);
      if (ph == 0) begin
        // flood the input while the output is held off
        hold_go = 1'b1;
        run_random(FLOOD_ITEMS);
      end
      park_and_drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (sb.awaited_rsp.size() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived", sb.awaited_rsp.size()));
    $display("Ran %0d list commands over four handshake pacing mixes and a long output stall;",
             sb.requests);
    $display("outcomes seen: %0d done, %0d full, %0d empty, %0d bad predecessor; %0d mismatches",
             sb.outcome_tally[ST_DONE], sb.outcome_tally[ST_FULL],
             sb.outcome_tally[ST_EMPTY], sb.outcome_tally[ST_BADPREV], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ale_pkg.sv
hw/rtl/ale_ctrl.sv
hw/rtl/ale_dpath.sv
hw/rtl/array_linked_list_engine.sv
verif/tb.sv
